// ===== rtl/slp_pkg.sv =====
package slp_pkg;

  // Default number of payload entries per buffer bank
  localparam int PAYLOAD_DEPTH_DEF = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_SYNC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_SYNC    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd3;

  // Configuration reset values
  localparam logic [7:0] FIRST_SYNC_RST  = 8'h55;
  localparam logic [7:0] REPORT_SYNC_RST = 8'h55;
  localparam logic [7:0] ACK_SYNC_RST    = 8'hAF;
  localparam logic [5:0] MAX_LENGTH_RST  = 6'd28;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  // Readout engine states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } back_state_t;

  // Descriptor of a verified packet, passed from parser to readout
  typedef struct packed {
    logic       bank;
    logic       is_ack;
    logic [7:0] message_id;
    logic [5:0] payload_length;
  } desc_t;

  // One result item
  typedef struct packed {
    logic       is_ack;
    logic [7:0] message_id;
    logic [5:0] payload_length;
    logic [4:0] byte_position;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

endpackage

// ===== rtl/slp_payload_ram.sv =====
module slp_payload_ram import slp_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/slp_desc_fifo.sv =====
module slp_desc_fifo import slp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_desc
);

  desc_t      entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_desc  = entry[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_desc;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("descriptor pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("descriptor popped from empty queue");

endmodule

// ===== rtl/slp_front.sv =====
module slp_front import slp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
  localparam int IDXW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // byte stream in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           rx_byte,
  // payload buffer write
  output logic                 wr_en,
  output logic [IDXW:0]        wr_addr,
  output logic [7:0]           wr_data,
  // descriptor queue
  input  logic                 q_full,
  output logic                 push,
  output desc_t                push_desc
);

  localparam logic [7:0] DEPTH_B = 8'(PAYLOAD_DEPTH);

  logic [7:0] first_sync;
  logic [7:0] report_sync;
  logic [7:0] ack_sync;
  logic [5:0] max_length;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] running_sum;
  logic [5:0] fill_index;
  logic [7:0] held_id;
  logic [5:0] held_length;
  logic       held_ack;
  logic       bank;

  logic       accept;
  logic [7:0] limit;
  logic       len_ok;
  logic [6:0] fill_inc;
  logic       fill_done;
  logic       sum_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= FIRST_SYNC_RST;
      report_sync <= REPORT_SYNC_RST;
      ack_sync    <= ACK_SYNC_RST;
      max_length  <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        CFG_REPORT_SYNC: report_sync <= cfg_data;
        CFG_ACK_SYNC:    ack_sync    <= cfg_data;
        CFG_MAX_LENGTH:  max_length  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Compare helpers
  assign accept    = in_valid && in_ready;
  assign limit     = ({2'b00, max_length} > DEPTH_B) ? DEPTH_B : {2'b00, max_length};
  assign len_ok    = (rx_byte <= limit);
  assign fill_inc  = {1'b0, fill_index} + 7'd1;
  assign fill_done = (fill_inc >= {1'b0, held_length});
  assign sum_ok    = (running_sum == rx_byte);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HUNT:  phase_next = (rx_byte == first_sync) ? PH_SYNC2 : PH_HUNT;
        PH_SYNC2: phase_next = (rx_byte == report_sync || rx_byte == ack_sync) ? PH_ID
                                                                               : PH_HUNT;
        PH_ID:    phase_next = PH_LEN;
        PH_LEN: begin
          if (!len_ok)              phase_next = PH_HUNT;
          else if (rx_byte != 8'd0) phase_next = PH_DATA;
          else                      phase_next = PH_SUM;
        end
        PH_DATA:  phase_next = fill_done ? PH_SUM : PH_DATA;
        PH_SUM:   phase_next = PH_HUNT;
        default:  phase_next = PH_HUNT;
      endcase
    end
  end

  // Outputs: stall only where the buffer bank or queue slot is needed
  always_comb begin
    in_ready = 1'b1;
    wr_en    = 1'b0;
    push     = 1'b0;
    unique case (phase)
      PH_DATA: begin
        in_ready = !q_full;
        wr_en    = accept;
      end
      PH_SUM: begin
        in_ready = !q_full;
        push     = accept && sum_ok;
      end
      default: ;
    endcase
  end

  assign wr_addr   = {bank, fill_index[IDXW-1:0]};
  assign wr_data   = rx_byte;
  assign push_desc = '{bank: bank, is_ack: held_ack, message_id: held_id,
                       payload_length: held_length};

  // Phase and bank select
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      bank  <= 1'b0;
    end else begin
      phase <= phase_next;
      if (push) bank <= ~bank;
    end
  end

  // Header capture and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
      fill_index  <= 6'd0;
      held_id     <= 8'd0;
      held_length <= 6'd0;
      held_ack    <= 1'b0;
    end else if (accept) begin
      case (phase)
        PH_HUNT: running_sum <= rx_byte;
        PH_SYNC2: begin
          if (rx_byte == report_sync)   held_ack <= 1'b0;
          else if (rx_byte == ack_sync) held_ack <= 1'b1;
          running_sum <= running_sum + rx_byte;
        end
        PH_ID: begin
          held_id     <= rx_byte;
          running_sum <= running_sum + rx_byte;
        end
        PH_LEN: begin
          if (len_ok) begin
            held_length <= rx_byte[5:0];
            fill_index  <= 6'd0;
            running_sum <= running_sum + rx_byte;
          end
        end
        PH_DATA: begin
          fill_index  <= fill_inc[5:0];
          running_sum <= running_sum + rx_byte;
        end
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      (phase == PH_DATA) |-> (fill_index < held_length))
    else $error("payload fill ran past packet length");
  a_write_no_stall: assert property (@(posedge clk) disable iff (rst)
      wr_en |-> !q_full)
    else $error("payload written while both banks are owned by readout");

endmodule

// ===== rtl/slp_back.sv =====
module slp_back import slp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
  localparam int IDXW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  // descriptor queue
  input  logic          q_valid,
  input  desc_t         q_desc,
  output logic          pop,
  // payload buffer read
  output logic          rd_en,
  output logic [IDXW:0] rd_addr,
  input  logic [7:0]    rd_data,
  // result stream out
  output logic          out_valid,
  input  logic          out_ready,
  output result_t       out_res
);

  back_state_t state;
  back_state_t state_next;
  logic [5:0]  k;
  logic [5:0]  k_sel;
  logic [6:0]  k_inc;
  logic        zero_len;
  logic        out_done;

  assign zero_len = (q_desc.payload_length == 6'd0);
  assign k_inc    = {1'b0, k} + 7'd1;
  assign out_done = out_valid && out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (q_valid) state_next = BK_FETCH;
      BK_FETCH: state_next = BK_SHOW;
      BK_SHOW: begin
        if (out_ready) state_next = out_res.last ? BK_IDLE : BK_FETCH;
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  // Read issue and queue pop
  always_comb begin
    rd_en     = 1'b0;
    k_sel     = 6'd0;
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      BK_IDLE:  rd_en = q_valid;
      BK_SHOW: begin
        out_valid = 1'b1;
        rd_en     = out_ready && !out_res.last;
        k_sel     = k_inc[5:0];
        pop       = out_ready && out_res.last;
      end
      default: ;
    endcase
  end

  assign rd_addr = {q_desc.bank, k_sel[IDXW-1:0]};

  // State and position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      k     <= 6'd0;
    end else begin
      state <= state_next;
      if (out_done) k <= out_res.last ? 6'd0 : k_inc[5:0];
    end
  end

  // Output register, loaded as the read data lands
  always_ff @(posedge clk) begin
    if (state == BK_FETCH) begin
      out_res.is_ack         <= q_desc.is_ack;
      out_res.message_id     <= q_desc.message_id;
      out_res.payload_length <= q_desc.payload_length;
      out_res.byte_position  <= k[4:0];
      out_res.payload_byte   <= zero_len ? 8'd0 : rd_data;
      out_res.last           <= zero_len || (k_inc == {1'b0, q_desc.payload_length});
    end
  end

  a_desc_held: assert property (@(posedge clk) disable iff (rst)
      (state != BK_IDLE) |-> q_valid)
    else $error("readout active without a queued descriptor");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
      pop |=> (state == BK_IDLE) && (k == 6'd0))
    else $error("readout did not return to idle after last result");

endmodule

// ===== rtl/sync_length_sum_packet_parser.sv =====
// Serial packet parser with two sync bytes, a length byte and an 8-bit
// additive checksum.
//
// Input channel s_axis: one received byte per transaction. Output channel
// m_axis: one result per payload byte of each packet whose checksum
// matches, or one header result for a zero-length packet; tlast marks the
// final result of a packet and tuser is set for an acknowledge packet.
// cfg_we/cfg_index/cfg_data write the sync values and the maximum length;
// write only while the block is idle.
// Bytes are taken at one per cycle unless stalled. The parser writes
// payload bytes into one of two buffer banks and hands a descriptor to
// the readout through a two-entry queue, so a new packet can be received
// while the previous one is read out. Each result passes through the
// registered buffer read and then the output register, and the next read
// starts only when the result is taken. Input stalls only in the payload
// and checksum phases while both banks are still owned by the readout.
// When the receiver holds tready low, the result stays in the output
// register and the parser keeps taking bytes until both banks are full.
// Reset (rst, synchronous) clears the registers to their defaults, empties
// the queue and returns the parser to the hunt for the first sync byte.
module sync_length_sum_packet_parser import slp_pkg::*; #(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] message_id, [13:8] payload_length, [18:14] byte_position,
  // [26:19] payload_byte, [31:27] zero
  output logic [31:0]          m_axis_tdata,
  output logic                 m_axis_tuser,   // [0] is_ack
  output logic                 m_axis_tlast
);

  localparam int IDXW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic          wr_en;
  logic [IDXW:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [IDXW:0] rd_addr;
  logic [7:0]    rd_data;
  logic          push;
  desc_t         push_desc;
  logic          q_full;
  logic          pop;
  logic          q_valid;
  desc_t         q_desc;
  result_t       res;

  slp_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .rx_byte   (s_axis_tdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  slp_payload_ram #(.AW(IDXW + 1)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slp_desc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_desc  (q_desc)
  );

  slp_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack result fields, lowest first; packet kind travels on tuser
  assign m_axis_tdata = {5'd0, res.payload_byte, res.byte_position, res.payload_length,
                         res.message_id};
  assign m_axis_tuser = res.is_ack;
  assign m_axis_tlast = res.last;

endmodule

// ===== dv/tb.sv =====
module tb;
  import slp_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] message_id, [13:8] payload_length, [18:14] byte_position,
  // [26:19] payload_byte, [31:27] zero
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;   // [0] is_ack
  logic        m_axis_tlast;

  always #5 clk = ~clk;

  sync_length_sum_packet_parser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow copy of the registers
  logic [7:0] sync1_cfg;
  logic [7:0] report_cfg;
  logic [7:0] ack_cfg;
  logic [5:0] maxlen_cfg;

  // Shadow copy of the parser
  phase_t     rx_phase;
  logic [7:0] rx_sum;
  logic [7:0] rx_id;
  logic [5:0] rx_len;
  logic       rx_ack;
  int         rx_fill;
  logic [7:0] rx_buf [PAYLOAD_DEPTH_DEF];

  // Results still owed by the block, oldest first
  result_t packet_results_q[$];

  int n_err = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_cfg = 0;
  int n_good_pkts = 0;
  int hold_req = 0;
  bit no_idle = 1'b0;

  function automatic void flag_fail(input string msg);
    n_err++;
    if (n_err <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int len_limit();
    return (maxlen_cfg > PAYLOAD_DEPTH_DEF) ? PAYLOAD_DEPTH_DEF : int'(maxlen_cfg);
  endfunction

  // Advance the shadow parser by one byte and queue any results it releases
  function automatic void parse_rx_byte(input logic [7:0] b);
    result_t r;
    case (rx_phase)
      PH_HUNT: begin
        if (b == sync1_cfg) rx_phase = PH_SYNC2;
        rx_sum = b;
      end
      PH_SYNC2: begin
        // report wins when both sync values are equal
        if (b == report_cfg) begin
          rx_ack = 1'b0;
          rx_phase = PH_ID;
        end else if (b == ack_cfg) begin
          rx_ack = 1'b1;
          rx_phase = PH_ID;
        end else begin
          rx_phase = PH_HUNT;
        end
        rx_sum = rx_sum + b;
      end
      PH_ID: begin
        rx_id = b;
        rx_sum = rx_sum + b;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        if (int'(b) <= len_limit()) begin
          rx_len = b[5:0];
          rx_fill = 0;
          rx_sum = rx_sum + b;
          rx_phase = (b != 8'd0) ? PH_DATA : PH_SUM;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (rx_fill < PAYLOAD_DEPTH_DEF) rx_buf[rx_fill] = b;
        rx_fill++;
        rx_sum = rx_sum + b;
        if (rx_fill >= rx_len) rx_phase = PH_SUM;
      end
      PH_SUM: begin
        if (rx_sum == b) begin
          n_good_pkts++;
          if (rx_len == 6'd0) begin
            r = '{is_ack: rx_ack, message_id: rx_id, payload_length: 6'd0,
                  byte_position: 5'd0, payload_byte: 8'd0, last: 1'b1};
            packet_results_q.push_back(r);
          end else begin
            for (int k = 0; k < rx_len && k < PAYLOAD_DEPTH_DEF; k++) begin
              r.is_ack = rx_ack;
              r.message_id = rx_id;
              r.payload_length = rx_len;
              r.byte_position = k[4:0];
              r.payload_byte = rx_buf[k];
              r.last = (k + 1 == rx_len);
              packet_results_q.push_back(r);
            end
          end
        end
        rx_phase = PH_HUNT;
      end
      default: rx_phase = PH_HUNT;
    endcase
  endfunction

  // One byte transaction on the input side
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    parse_rx_byte(b);
    n_bytes++;
  endtask

  // Full packet; fill < 0 gives random payload, sum_err corrupts the checksum
  task automatic send_packet(input logic [7:0] kind, input logic [7:0] id,
                             input logic [7:0] len, input int fill,
                             input logic [7:0] sum_err);
    logic [7:0] s;
    logic [7:0] p;
    s = sync1_cfg + kind + id + len;
    send_byte(sync1_cfg);
    send_byte(kind);
    send_byte(id);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      p = (fill < 0) ? 8'($urandom) : 8'(fill);
      s = s + p;
      send_byte(p);
    end
    send_byte(s + sum_err);
  endtask

  // Stop offering and wait for every owed result, then let the readout settle
  task automatic wait_results_done();
    int waited;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (packet_results_q.size() != 0 && waited < 40000) begin
      @(posedge clk);
      waited++;
    end
    if (packet_results_q.size() != 0) begin
      flag_fail($sformatf("%0d expected results never arrived",
                          packet_results_q.size()));
      packet_results_q.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  // Write all four registers back to back while idle
  task automatic set_config(input logic [7:0] f, input logic [7:0] rp,
                            input logic [7:0] ak, input logic [7:0] ml);
    wait_results_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_SYNC;
    cfg_data  <= f;
    @(negedge clk);
    cfg_index <= CFG_REPORT_SYNC;
    cfg_data  <= rp;
    @(negedge clk);
    cfg_index <= CFG_ACK_SYNC;
    cfg_data  <= ak;
    @(negedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data  <= ml;
    @(negedge clk);
    cfg_we <= 1'b0;
    sync1_cfg  = f;
    report_cfg = rp;
    ack_cfg    = ak;
    maxlen_cfg = ml[5:0];
    n_cfg++;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_req--;
        m_axis_tready <= 1'b0;
      end else begin
        if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
        if (stall > 0) begin
          stall--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Compare each result transaction with the oldest owed result
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
             m_axis_tdata[18:14], m_axis_tdata[26:19], m_axis_tlast};
      if (packet_results_q.size() == 0) begin
        flag_fail($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                            m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = packet_results_q.pop_front();
        n_results++;
        if (got !== want || m_axis_tdata[31:27] !== 5'd0)
          flag_fail($sformatf({"expected ack=%0d id=%h len=%0d pos=%0d byte=%h last=%0d,",
                               " got ack=%0d id=%h len=%0d pos=%0d byte=%h last=%0d pad=%h"},
                              want.is_ack, want.message_id, want.payload_length,
                              want.byte_position, want.payload_byte, want.last,
                              got.is_ack, got.message_id, got.payload_length,
                              got.byte_position, got.payload_byte, got.last,
                              m_axis_tdata[31:27]));
      end
    end
  end

  // Default registers: sync extremes, both packet kinds, checksum and length faults
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h12);
    send_packet(REPORT_SYNC_RST, 8'h00, 8'd0, -1, 8'd0);
    send_packet(ACK_SYNC_RST, 8'hFF, 8'd0, -1, 8'd0);
    send_packet(ACK_SYNC_RST, 8'h01, 8'd1, 8'hFF, 8'd0);
    send_packet(REPORT_SYNC_RST, 8'h80, 8'd6, 8'h00, 8'd0);
    send_packet(ACK_SYNC_RST, 8'h7E, 8'd28, 8'hFF, 8'd0);
    send_packet(REPORT_SYNC_RST, 8'h33, 8'd4, -1, 8'd1);
    // length one above the maximum: the parser goes back to the hunt
    send_byte(FIRST_SYNC_RST);
    send_byte(REPORT_SYNC_RST);
    send_byte(8'h34);
    send_byte(8'd29);
    // bad second sync
    send_byte(FIRST_SYNC_RST);
    send_byte(8'h12);
    send_packet(ACK_SYNC_RST, 8'h35, 8'd2, -1, 8'd0);
    // a rejected length byte equal to the first sync must not restart a packet
    send_byte(FIRST_SYNC_RST);
    send_byte(REPORT_SYNC_RST);
    send_byte(8'h09);
    send_byte(FIRST_SYNC_RST);
    send_byte(ACK_SYNC_RST);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h57);
    // length byte at its top value
    send_byte(FIRST_SYNC_RST);
    send_byte(ACK_SYNC_RST);
    send_byte(8'h10);
    send_byte(8'hFF);
    send_packet(REPORT_SYNC_RST, 8'h36, 8'd3, -1, 8'd0);
  endtask

  // Register extremes: equal syncs, zero and full lengths, limit above the buffer
  task automatic test_config_extremes();
    set_config(8'h00, 8'hFF, 8'hFF, 8'h00);
    send_packet(8'hFF, 8'h11, 8'd0, -1, 8'd0);
    send_packet(8'hFF, 8'h12, 8'd1, -1, 8'd0);
    send_packet(8'hFF, 8'h13, 8'd0, -1, 8'h80);
    send_packet(8'hFF, 8'h14, 8'd0, -1, 8'd0);

    set_config(8'hFF, 8'h00, 8'h01, 8'hFF);
    send_packet(8'h01, 8'h20, 8'd32, -1, 8'd0);
    send_packet(8'h00, 8'h21, 8'd3, 8'hA5, 8'd0);
    // length one above the buffer
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h22);
    send_byte(8'd33);
    send_packet(8'h01, 8'h23, 8'd5, -1, 8'd0);

    // bad second sync equal to the first sync is not a new start
    set_config(8'hA5, 8'h5A, 8'h3C, 8'h20);
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_packet(8'h3C, 8'h30, 8'd2, -1, 8'd0);
    send_packet(8'h5A, 8'h31, 8'd32, -1, 8'd0);

    set_config(8'h55, 8'h55, 8'hAF, 8'h01);
    send_packet(8'hAF, 8'h40, 8'd1, -1, 8'd0);
    send_packet(8'h55, 8'h41, 8'd2, -1, 8'd0);
    send_packet(8'h55, 8'h42, 8'd0, -1, 8'd0);
  endtask

  // Long receiver hold-off while packets keep arriving back to back
  task automatic test_backpressure();
    set_config(FIRST_SYNC_RST, REPORT_SYNC_RST, ACK_SYNC_RST, 8'(MAX_LENGTH_RST));
    no_idle = 1'b1;
    hold_req = 400;
    for (int i = 0; i < 4; i++)
      send_packet((i % 2) ? ACK_SYNC_RST : REPORT_SYNC_RST, 8'(8'h60 + i),
                  8'($urandom_range(3, 6)), -1, 8'd0);
    no_idle = 1'b0;
    wait_results_done();
  endtask

  // Mostly well-formed packets with random content, some noise and broken ones
  task automatic test_random();
    int since_cfg;
    int r;
    int lim;
    logic [7:0] kind;
    logic [7:0] len;
    logic [7:0] b;
    since_cfg = 0;
    while (n_bytes < 370) begin
      if (since_cfg >= 10 && $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 4);
        b = 8'($urandom);
        case (r)
          0: set_config(FIRST_SYNC_RST, REPORT_SYNC_RST, ACK_SYNC_RST,
                        8'(MAX_LENGTH_RST));
          1: set_config(8'($urandom), b, b, 8'($urandom_range(0, 63)));
          2: set_config(8'($urandom), b, 8'($urandom), 8'h20);
          3: set_config(8'($urandom), b, 8'($urandom), 8'($urandom_range(0, 3)));
          default: set_config(8'($urandom), b, 8'($urandom), 8'($urandom));
        endcase
        since_cfg = 0;
      end
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
      if ($urandom_range(0, 24) == 0) wait_results_done();
      lim = len_limit();
      kind = $urandom_range(0, 1) ? ack_cfg : report_cfg;
      r = $urandom_range(0, 99);
      if (r < 72) begin
        if ($urandom_range(0, 19) == 0) len = 8'(lim);
        else if ($urandom_range(0, 5) == 0) len = 8'($urandom_range(0, lim));
        else len = 8'($urandom_range(0, (lim < 6) ? lim : 6));
        send_packet(kind, 8'($urandom), len, -1,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
        since_cfg++;
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (r < 88) begin
        send_byte(sync1_cfg);
        b = 8'($urandom);
        while (b == report_cfg || b == ack_cfg) b = 8'($urandom);
        send_byte(b);
      end else if (r < 94) begin
        send_byte(sync1_cfg);
        send_byte(kind);
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(lim + 1, 255)));
      end else begin
        // header then a short payload; the next bytes continue the packet
        send_byte(sync1_cfg);
        send_byte(kind);
        send_byte(8'($urandom));
        len = 8'($urandom_range(0, lim));
        send_byte(len);
        repeat ($urandom_range(0, len)) send_byte(8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_FIRST_SYNC;
    cfg_data      = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    sync1_cfg     = FIRST_SYNC_RST;
    report_cfg    = REPORT_SYNC_RST;
    ack_cfg       = ACK_SYNC_RST;
    maxlen_cfg    = MAX_LENGTH_RST;
    rx_phase      = PH_HUNT;
    rx_sum        = 8'd0;
    rx_id         = 8'd0;
    rx_len        = 6'd0;
    rx_ack        = 1'b0;
    rx_fill       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_results_done();

    $display("Sent %0d bytes over %0d register settings; %0d good packets gave %0d results.",
             n_bytes, n_cfg, n_good_pkts, n_results);
    $display("Included a 400-cycle receiver hold-off and drains between phases.");
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures", n_err);
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Timeout with %0d results still owed", packet_results_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
